### hw/rtl/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

   localparam int MAX_COLUMNS  = 64;
   localparam int MAX_ELEMENTS = 512;

   localparam int OCC_W  = 16;
   localparam int CFG_W  = 7;
   localparam int COST_W = 11;

   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_W  = $clog2(MAX_ELEMENTS + 2);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int PROD_W = ROW_W + COL_W;

   localparam logic [CFG_W-1:0]  GRID_COLUMNS_RESET = CFG_W'(4);
   localparam logic [COST_W-1:0] COST_LIMIT         = COST_W'(2047);

   typedef struct packed {
      logic [ROW_W-1:0] min_row;
      logic [ROW_W-1:0] max_row;
      logic [COL_W-1:0] min_column;
      logic [COL_W-1:0] max_column;
      logic [CNT_W-1:0] occupied_count;
      logic             any_occupied;
      logic             error_seen;
   } bbc_net_type;

   localparam bbc_net_type NET_CLEAR = '0;

endpackage

### hw/rtl/bbc_req_if.sv
`timescale 1ns / 1ps

interface bbc_req_if import bbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OCC_W-1:0] occupancy;
   logic             last_element;

   modport source (output valid, output occupancy, output last_element, input ready);
   modport sink   (input valid, input occupancy, input last_element, output ready);
endinterface

### hw/rtl/bbc_rsp_if.sv
`timescale 1ns / 1ps

interface bbc_rsp_if import bbc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] net_cost;
   logic              error;

   modport source (output valid, output net_cost, output error, input ready);
   modport sink   (input valid, input net_cost, input error, output ready);
endinterface

### hw/rtl/bbc_csr_if.sv
`timescale 1ns / 1ps

interface bbc_csr_if import bbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] grid_columns;

   modport source (output valid, output grid_columns, input ready);
   modport sink   (input valid, input grid_columns, output ready);
endinterface

### hw/rtl/bbc_track.sv
`timescale 1ns / 1ps

module bbc_track import bbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] grid_columns,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OCC_W-1:0] occupancy,
   input  logic             last_element,
   output logic             snap_valid,
   input  logic             snap_ready,
   output bbc_net_type      snap
);

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] element_ff, element_in;
   bbc_net_type      net_ff, net_in;
   bbc_net_type      snap_ff;
   logic             snap_valid_ff;
   logic [COL_W-1:0] eff_columns;
   logic             accept;
   logic             negative;
   logic             positive;

   assign req_ready  = !snap_valid_ff || snap_ready;
   assign accept     = req_valid && req_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   assign negative = occupancy[OCC_W-1];
   assign positive = !negative && (occupancy != '0);

   always_comb begin
      if (grid_columns == '0) begin
         eff_columns = COL_W'(1);
      end else if (int'(grid_columns) > MAX_COLUMNS) begin
         eff_columns = COL_W'(MAX_COLUMNS);
      end else begin
         eff_columns = COL_W'(grid_columns);
      end
   end

   always_comb begin
      column_in  = column_ff;
      row_in     = row_ff;
      element_in = element_ff;
      net_in     = net_ff;
      if (element_ff >= CNT_W'(MAX_ELEMENTS)) begin
         net_in.error_seen = 1'b1;
      end else begin
         element_in = element_ff + CNT_W'(1);
         if (negative) begin
            net_in.error_seen = 1'b1;
         end else if (positive) begin
            net_in.occupied_count = net_ff.occupied_count + CNT_W'(1);
            net_in.any_occupied   = 1'b1;
            if (!net_ff.any_occupied) begin
               net_in.min_row    = row_ff;
               net_in.max_row    = row_ff;
               net_in.min_column = column_ff;
               net_in.max_column = column_ff;
            end else begin
               if (row_ff < net_ff.min_row) net_in.min_row = row_ff;
               if (row_ff > net_ff.max_row) net_in.max_row = row_ff;
               if (column_ff < net_ff.min_column) net_in.min_column = column_ff;
               if (column_ff > net_ff.max_column) net_in.max_column = column_ff;
            end
         end
         if (column_ff >= eff_columns) begin
            column_in = COL_W'(1);
            row_in    = row_ff + ROW_W'(1);
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= COL_W'(1);
         row_ff        <= ROW_W'(1);
         element_ff    <= '0;
         net_ff        <= NET_CLEAR;
         snap_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (last_element) begin
               column_ff  <= COL_W'(1);
               row_ff     <= ROW_W'(1);
               element_ff <= '0;
               net_ff     <= NET_CLEAR;
            end else begin
               column_ff  <= column_in;
               row_ff     <= row_in;
               element_ff <= element_in;
               net_ff     <= net_in;
            end
         end
         if (accept && last_element) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_element) begin
         snap_ff <= net_in;
      end
   end

endmodule

### hw/rtl/bbc_cost.sv
`timescale 1ns / 1ps

module bbc_cost import bbc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   output logic              snap_ready,
   input  bbc_net_type       snap,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [COST_W-1:0] net_cost,
   output logic              error
);

   logic              rsp_valid_ff;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              error_ff;
   logic [ROW_W-1:0]  height;
   logic [COL_W-1:0]  width;
   logic [PROD_W-1:0] area;
   logic [PROD_W:0]   total;

   assign snap_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign net_cost   = cost_ff;
   assign error      = error_ff;

   assign height = snap.max_row - snap.min_row + ROW_W'(1);
   assign width  = snap.max_column - snap.min_column + COL_W'(1);
   assign area   = PROD_W'(height) * PROD_W'(width);
   assign total  = {1'b0, area} + (PROD_W + 1)'(snap.occupied_count);

   always_comb begin
      if (snap.error_seen || !snap.any_occupied) begin
         cost_in = '0;
      end else if (total > (PROD_W + 1)'(COST_LIMIT)) begin
         cost_in = COST_LIMIT;
      end else begin
         cost_in = COST_W'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && snap_ready) begin
         cost_ff  <= cost_in;
         error_ff <= snap.error_seen;
      end
   end

endmodule

### hw/rtl/grid_net_bounding_box_cost.sv
`timescale 1ns / 1ps

// Bounding-box cost of one net over a row-major grid of subareas.
// req: one word per subarea, its terminal count and a last marker closing
//   the net. Words of a net arrive in row-major order.
// rsp: one word per net, issued for the word marked last: box area plus
//   occupied count, capped at 2047; 0 with error set on a negative count
//   or over 512 words (the element limit); 0, error clear, if none occupied.
// csr: grid width, always ready; write only while no net is in flight.
// Throughput: one req word per cycle while req ready is high. The running
//   min/max/count update is a single register stage, so a new net may
//   start right after a last word. The last word closes the net into a
//   snapshot register; the area multiply and saturate are then registered.
// Reset clears the net state and response valid and sets the width to 4.
// A stalled rsp holds its word; one closed net waits in the middle stage,
//   after which req ready drops until rsp is taken.

module grid_net_bounding_box_cost import bbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bbc_req_if.sink   req_port,
   bbc_rsp_if.source rsp_port,
   bbc_csr_if.sink   csr_port
);

   logic [CFG_W-1:0] grid_columns_ff;
   logic             snap_valid;
   logic             snap_ready;
   bbc_net_type      snap;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_COLUMNS_RESET;
      end else if (csr_port.valid) begin
         grid_columns_ff <= csr_port.grid_columns;
      end
   end

   bbc_track u_track (
      .clock        (clock),
      .reset        (reset),
      .grid_columns (grid_columns_ff),
      .req_valid    (req_port.valid),
      .req_ready    (req_port.ready),
      .occupancy    (req_port.occupancy),
      .last_element (req_port.last_element),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap)
   );

   bbc_cost u_cost (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_valid  (rsp_port.valid),
      .rsp_ready  (rsp_port.ready),
      .net_cost   (rsp_port.net_cost),
      .error      (rsp_port.error)
   );

endmodule

### hw/rtl/bbc_checker.sv
`timescale 1ns / 1ps

module bbc_checker import bbc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [COST_W-1:0] rsp_net_cost,
   input logic              rsp_error
);

   // error word always carries zero cost
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_net_cost == '0)
      else $error("error word with nonzero cost");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_net_cost) && $stable(rsp_error))
      else $error("stalled rsp word changed");

   // a fresh rsp word comes from a last req word taken through the snapshot and cost registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
      else $error("rsp word without a closing req word");

endmodule

bind grid_net_bounding_box_cost bbc_checker u_bbc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .req_last     (req_port.last_element),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .rsp_net_cost (rsp_port.net_cost),
   .rsp_error    (rsp_port.error)
);
